// File: hw/rtl/eid_pkg.sv
// Shared constants and codes for the entity ID allocator.
`default_nettype none
package eid_pkg;

	// pool size and derived widths
	localparam int ENTRY_COUNT = 1024;
	localparam int ID_W        = 10;
	localparam int ADDR_W      = $clog2(ENTRY_COUNT);
	localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

	localparam logic [CNT_W-1:0]  ENTRY_CNT = CNT_W'(ENTRY_COUNT);
	localparam logic [ADDR_W-1:0] ADDR_MAX  = ADDR_W'(ENTRY_COUNT - 1);

	// request modes
	localparam logic [2:0] MODE_ALLOC  = 3'd0;
	localparam logic [2:0] MODE_CREATE = 3'd1;
	localparam logic [2:0] MODE_FREE   = 3'd2;
	localparam logic [2:0] MODE_QUERY  = 3'd3;
	localparam logic [2:0] MODE_FILL   = 3'd4;

	// response status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EXISTS   = 3'd2;
	localparam logic [2:0] ST_MISSING  = 3'd3;
	localparam logic [2:0] ST_ROOT     = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

endpackage
`default_nettype wire

// File: hw/rtl/eid_req_if.sv
// Request channel: mode and entity ID.
`default_nettype none
interface eid_req_if;
	logic                    valid;
	logic                    ready;
	logic [2:0]              mode;
	logic [eid_pkg::ID_W-1:0] entity_id;

	modport source (output valid, output mode, output entity_id, input ready);
	modport sink   (input valid, input mode, input entity_id, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/eid_rsp_if.sv
// Response channel: resulting ID and status.
`default_nettype none
interface eid_rsp_if;
	logic                    valid;
	logic                    ready;
	logic [eid_pkg::ID_W-1:0] result_id;
	logic [2:0]              status;

	modport source (output valid, output result_id, output status, input ready);
	modport sink   (input valid, input result_id, input status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/eid_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module eid_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/entity_id_allocator.sv
// Top level of the entity ID allocator: sequencer, exists map and free-ID stack.
`default_nettype none
// Hands out, creates, frees and checks 10-bit entity IDs. State lives in two
// synchronous RAMs: a 1024x1 exists map and a 1024x10 LIFO stack of freed IDs,
// plus a next-ID high-water counter and a stack count. Allocate, create-at,
// free, query and unused modes go through S_IDLE and S_EXEC: the accept cycle
// issues the RAM reads, then S_EXEC consumes the read data, writes back and
// loads the response register once that register is free, so a new request
// is taken on the cycle after that even if the response is still waiting.
// Fill-holes walks the map one ID at a time below next_id (read in S_FILL_RD,
// write in S_FILL_WR), then answers from S_FIN. After reset a clearing pass
// zeroes the exists map, one entry per cycle; no request is accepted until it ends.
module entity_id_allocator (
	input  wire logic clk,
	input  wire logic arst_n,
	eid_req_if.sink   req,
	eid_rsp_if.source rsp
);

	typedef enum logic [5:0] {
		S_CLEAR   = 6'b000001,
		S_IDLE    = 6'b000010,
		S_EXEC    = 6'b000100,
		S_FILL_RD = 6'b001000,
		S_FILL_WR = 6'b010000,
		S_FIN     = 6'b100000
	} state_t;

	state_t                         state_q, state_d;
	logic [eid_pkg::CNT_W-1:0]      next_id_q, next_id_d;
	logic [eid_pkg::CNT_W-1:0]      stack_count_q, stack_count_d;
	logic [2:0]                     mode_q, mode_d;
	logic [eid_pkg::ID_W-1:0]       id_q, id_d;
	logic [eid_pkg::ADDR_W-1:0]     k_q, k_d;
	logic [eid_pkg::ADDR_W-1:0]     clr_q, clr_d;
	logic                           ovf_q, ovf_d;
	logic                           out_valid_q;
	logic [eid_pkg::ID_W-1:0]       out_id_q;
	logic [2:0]                     out_st_q;

	logic                           out_free;
	logic                           out_load;
	logic [eid_pkg::ID_W-1:0]       res_id;
	logic [2:0]                     res_st;

	// exists map port signals
	logic                           ex_we, ex_re;
	logic [eid_pkg::ADDR_W-1:0]     ex_waddr, ex_raddr;
	logic                           ex_wdata, ex_rdata;

	// free stack port signals
	logic                           stk_we, stk_re;
	logic [eid_pkg::ADDR_W-1:0]     stk_waddr, stk_raddr;
	logic [eid_pkg::ID_W-1:0]       stk_wdata, stk_rdata;

	logic                           id_in_pool;
	logic                           fill_last;

	eid_ram #(.WIDTH(1), .DEPTH(eid_pkg::ENTRY_COUNT)) u_exists_ram (
		.clk   (clk),
		.we    (ex_we),
		.waddr (ex_waddr),
		.wdata (ex_wdata),
		.re    (ex_re),
		.raddr (ex_raddr),
		.rdata (ex_rdata)
	);

	eid_ram #(.WIDTH(eid_pkg::ID_W), .DEPTH(eid_pkg::ENTRY_COUNT)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign req.ready  = (state_q == S_IDLE);
	assign out_free   = !out_valid_q || rsp.ready;
	assign id_in_pool = ({1'b0, id_q} < eid_pkg::ENTRY_CNT);
	assign fill_last  = ({1'b0, k_q} == (next_id_q - eid_pkg::CNT_W'(1)));

	// sequencer: read on accept, modify and write back in S_EXEC; clear pass and fill walk
	always_comb begin
		state_d       = state_q;
		next_id_d     = next_id_q;
		stack_count_d = stack_count_q;
		mode_d        = mode_q;
		id_d          = id_q;
		k_d           = k_q;
		clr_d         = clr_q;
		ovf_d         = ovf_q;
		out_load      = 1'b0;
		res_id        = '0;
		res_st        = eid_pkg::ST_OK;
		ex_we         = 1'b0;
		ex_waddr      = id_q;
		ex_wdata      = 1'b1;
		ex_re         = 1'b0;
		ex_raddr      = req.entity_id;
		stk_we        = 1'b0;
		stk_waddr     = stack_count_q[eid_pkg::ADDR_W-1:0];
		stk_wdata     = id_q;
		stk_re        = 1'b0;
		stk_raddr     = eid_pkg::ADDR_W'(stack_count_q - eid_pkg::CNT_W'(1));

		case (state_q)
			S_CLEAR: begin
				ex_we    = 1'b1;
				ex_waddr = clr_q;
				ex_wdata = 1'b0;
				clr_d    = clr_q + eid_pkg::ADDR_W'(1);
				if (clr_q == eid_pkg::ADDR_MAX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					mode_d = req.mode;
					id_d   = req.entity_id;
					if (req.mode == eid_pkg::MODE_FILL) begin
						k_d     = '0;
						ovf_d   = 1'b0;
						state_d = (next_id_q == '0) ? S_FIN : S_FILL_RD;
					end else begin
						ex_re  = 1'b1;
						stk_re = 1'b1;
						if (req.mode == eid_pkg::MODE_ALLOC) begin
							ex_raddr = next_id_q[eid_pkg::ADDR_W-1:0];
						end
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					case (mode_q)
						eid_pkg::MODE_ALLOC: begin
							if (stack_count_q != '0) begin
								// reuse the most recently freed ID
								stack_count_d = stack_count_q - eid_pkg::CNT_W'(1);
								res_id        = stk_rdata;
							end else if (next_id_q == eid_pkg::ENTRY_CNT) begin
								res_st = eid_pkg::ST_FULL;
							end else begin
								res_id    = next_id_q[eid_pkg::ID_W-1:0];
								next_id_d = next_id_q + eid_pkg::CNT_W'(1);
								ex_waddr  = next_id_q[eid_pkg::ADDR_W-1:0];
								if (ex_rdata) begin
									res_st = eid_pkg::ST_EXISTS;
								end else begin
									ex_we = 1'b1;
								end
							end
						end
						eid_pkg::MODE_CREATE: begin
							res_id = id_q;
							if (!id_in_pool) begin
								res_st = eid_pkg::ST_FULL;
							end else if (ex_rdata) begin
								res_st = eid_pkg::ST_EXISTS;
							end else begin
								ex_we = 1'b1;
								if ({1'b0, id_q} >= next_id_q) begin
									next_id_d = {1'b0, id_q} + eid_pkg::CNT_W'(1);
								end
							end
						end
						eid_pkg::MODE_FREE: begin
							res_id = id_q;
							if (id_q == '0) begin
								res_st = eid_pkg::ST_ROOT;
							end else if (!id_in_pool || !ex_rdata) begin
								res_st = eid_pkg::ST_MISSING;
							end else if (stack_count_q == eid_pkg::ENTRY_CNT) begin
								res_st = eid_pkg::ST_OVERFLOW;
							end else begin
								stk_we        = 1'b1;
								stack_count_d = stack_count_q + eid_pkg::CNT_W'(1);
							end
						end
						eid_pkg::MODE_QUERY: begin
							res_id = id_q;
							if (!id_in_pool || !ex_rdata) begin
								res_st = eid_pkg::ST_MISSING;
							end
						end
						default: begin
							res_id = '0;
							res_st = eid_pkg::ST_OK;
						end
					endcase
				end
			end
			S_FILL_RD: begin
				ex_re    = 1'b1;
				ex_raddr = k_q;
				state_d  = S_FILL_WR;
			end
			S_FILL_WR: begin
				// create a missing ID and push it unless the stack is full
				if (!ex_rdata) begin
					ex_we    = 1'b1;
					ex_waddr = k_q;
					if (stack_count_q == eid_pkg::ENTRY_CNT) begin
						ovf_d = 1'b1;
					end else begin
						stk_we        = 1'b1;
						stk_wdata     = k_q;
						stack_count_d = stack_count_q + eid_pkg::CNT_W'(1);
					end
				end
				k_d     = k_q + eid_pkg::ADDR_W'(1);
				state_d = fill_last ? S_FIN : S_FILL_RD;
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					res_id   = '0;
					res_st   = ovf_q ? eid_pkg::ST_OVERFLOW : eid_pkg::ST_OK;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			next_id_q     <= '0;
			stack_count_q <= '0;
			clr_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			next_id_q     <= next_id_d;
			stack_count_q <= stack_count_d;
			clr_q         <= clr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and walk payload
	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		id_q   <= id_d;
		k_q    <= k_d;
		ovf_q  <= ovf_d;
	end

	// response register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_id_q <= res_id;
			out_st_q <= res_st;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.result_id = out_id_q;
	assign rsp.status    = out_st_q;

`ifndef ASSERT_OFF
	// counters never pass the pool size
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(next_id_q <= eid_pkg::ENTRY_CNT) && (stack_count_q <= eid_pkg::ENTRY_CNT))
		else $error("next_id or stack count beyond pool size");

	// high-water mark only moves up
	a_next_id_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (next_id_q >= $past(next_id_q)))
		else $error("next_id decreased");

	// one request in flight: no accept on the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in work");

	// a response is only produced from the execute or finish step
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_FIN))
		else $error("response raised outside execute or finish");
`endif

endmodule
`default_nettype wire

// File: dv/entity_id_allocator_tb.sv
// Self-checking testbench for the entity ID allocator: random and directed words, scoreboard.
`timescale 1ns / 100ps

module entity_id_allocator_tb;

	localparam int         HOLD_CYCLES    = 300;
	localparam int         CYCLE_LIMIT    = 600000;
	localparam int         TAIL_CYCLES    = 10;
	localparam int         GAP_PERCENT    = 22;
	localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [2:0] MODE_SPARE_MID = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [eid_pkg::ID_W-1:0] rid;
		logic [2:0]               status;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	eid_req_if req_ch ();
	eid_rsp_if rsp_ch ();

	entity_id_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// allocator state as the testbench sees it
	bit                       id_live   [eid_pkg::ENTRY_COUNT];
	logic [eid_pkg::ID_W-1:0] freed_ids [eid_pkg::ENTRY_COUNT];
	int                       freed_depth = 0;
	int                       high_water  = 0;

	outcome_t pending_outcomes [$];

	int fail_count   = 0;
	int cycle_count  = 0;
	int mode_count   [8];
	int status_count [8];

	// stall control shared by both sides
	bit no_gaps   = 1'b0;
	int hold_ask  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, pending_outcomes.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic bit push_freed(input logic [eid_pkg::ID_W-1:0] id);
		if (freed_depth >= eid_pkg::ENTRY_COUNT)
			return 1'b0;
		freed_ids[freed_depth] = id;
		freed_depth++;
		return 1'b1;
	endfunction

	// next response for one request; updates the tracked state
	function automatic outcome_t allocator_outcome(input logic [2:0] m,
		input logic [eid_pkg::ID_W-1:0] id);
		outcome_t o;
		o.rid    = '0;
		o.status = eid_pkg::ST_OK;
		case (m)
			eid_pkg::MODE_ALLOC: begin
				if (freed_depth > 0) begin
					freed_depth--;
					o.rid = freed_ids[freed_depth];
				end else if (high_water >= eid_pkg::ENTRY_COUNT) begin
					o.status = eid_pkg::ST_FULL;
				end else begin
					o.rid = eid_pkg::ID_W'(high_water);
					high_water++;
					if (id_live[o.rid])
						o.status = eid_pkg::ST_EXISTS;
					else
						id_live[o.rid] = 1'b1;
				end
			end
			eid_pkg::MODE_CREATE: begin
				o.rid = id;
				if (int'(id) >= eid_pkg::ENTRY_COUNT) begin
					o.status = eid_pkg::ST_FULL;
				end else if (id_live[id]) begin
					o.status = eid_pkg::ST_EXISTS;
				end else begin
					if (int'(id) >= high_water)
						high_water = int'(id) + 1;
					id_live[id] = 1'b1;
				end
			end
			eid_pkg::MODE_FREE: begin
				o.rid = id;
				if (id == '0)
					o.status = eid_pkg::ST_ROOT;
				else if (int'(id) >= eid_pkg::ENTRY_COUNT || !id_live[id])
					o.status = eid_pkg::ST_MISSING;
				else if (!push_freed(id))
					o.status = eid_pkg::ST_OVERFLOW;
			end
			eid_pkg::MODE_QUERY: begin
				o.rid = id;
				if (int'(id) >= eid_pkg::ENTRY_COUNT || !id_live[id])
					o.status = eid_pkg::ST_MISSING;
			end
			eid_pkg::MODE_FILL: begin
				// every missing ID below the counter gets created and pushed while the list has room
				for (int k = 0; k < high_water && k < eid_pkg::ENTRY_COUNT; k++) begin
					if (!id_live[k]) begin
						id_live[k] = 1'b1;
						if (!push_freed(eid_pkg::ID_W'(k)))
							o.status = eid_pkg::ST_OVERFLOW;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// random existing ID other than the root
	function automatic logic [eid_pkg::ID_W-1:0] pick_live_id();
		logic [eid_pkg::ID_W-1:0] id;
		do
			id = eid_pkg::ID_W'($urandom_range(1, high_water - 1));
		while (!id_live[id]);
		return id;
	endfunction

	// response side: check accepted words, then drive ready for the next edge
	always @(posedge clk) begin : rsp_side
		outcome_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				fail_count++;
				$display("%0t: word with nothing expected: id %0d status %0d", $time,
					rsp_ch.result_id, rsp_ch.status);
			end else begin
				want = pending_outcomes.pop_front();
				status_count[rsp_ch.status]++;
				if (rsp_ch.result_id !== want.rid) begin
					fail_count++;
					$display("%0t: result_id expected %0d, got %0d", $time, want.rid,
						rsp_ch.result_id);
				end
				if (rsp_ch.status !== want.status) begin
					fail_count++;
					$display("%0t: status expected %0d, got %0d (id %0d)", $time,
						want.status, rsp_ch.status, want.rid);
				end
			end
		end
		if (hold_ask != hold_seen) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (no_gaps) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= GAP_PERCENT);
		end
	end

	// offer one word and wait for it to be taken; valid stays up unless a gap follows
	task automatic send_word(input logic [2:0] m, input logic [eid_pkg::ID_W-1:0] id);
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= m;
		req_ch.entity_id <= id;
		do
			@(posedge clk);
		while (!(arst_n && req_ch.ready === 1'b1));
		pending_outcomes = {pending_outcomes, allocator_outcome(m, id)};
		mode_count[m]++;
		if (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every expected word has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// mostly well-formed traffic around the current high-water mark, some noise
	task automatic send_mixed_word();
		int                       pick;
		int                       top;
		logic [2:0]               m;
		logic [eid_pkg::ID_W-1:0] id;
		pick = $urandom_range(99);
		top  = (high_water + 10 > eid_pkg::ENTRY_COUNT - 2) ? eid_pkg::ENTRY_COUNT - 2 :
			high_water + 10;
		id   = eid_pkg::ID_W'($urandom);
		if (pick < 30) begin
			m = eid_pkg::MODE_ALLOC;
		end else if (pick < 45) begin
			m  = eid_pkg::MODE_CREATE;
			id = eid_pkg::ID_W'($urandom_range(0, top));
		end else if (pick < 70) begin
			m    = eid_pkg::MODE_FREE;
			pick = $urandom_range(9);
			if (pick == 0)
				id = '0;
			else if (pick < 8 && high_water > 1)
				id = eid_pkg::ID_W'($urandom_range(1, high_water - 1));
		end else if (pick < 92) begin
			m = eid_pkg::MODE_QUERY;
			if ($urandom_range(1))
				id = eid_pkg::ID_W'($urandom_range(0, top));
		end else if (pick < 94) begin
			m = eid_pkg::MODE_FILL;
		end else if (pick < 97) begin
			m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		end else begin
			m = 3'($urandom);
		end
		send_word(m, id);
	endtask

	// hand-picked words: every mode, field extremes, refused and reused IDs
	task automatic test_directed();
		send_word(eid_pkg::MODE_ALLOC, eid_pkg::ID_W'(eid_pkg::ENTRY_COUNT - 1));
		send_word(eid_pkg::MODE_ALLOC, '0);
		send_word(eid_pkg::MODE_CREATE, eid_pkg::ID_W'(1));
		send_word(eid_pkg::MODE_CREATE, eid_pkg::ID_W'(5));
		send_word(eid_pkg::MODE_ALLOC, '1);
		send_word(eid_pkg::MODE_QUERY, eid_pkg::ID_W'(5));
		send_word(eid_pkg::MODE_QUERY, eid_pkg::ID_W'(3));
		send_word(eid_pkg::MODE_QUERY, '0);
		send_word(eid_pkg::MODE_QUERY, '1);
		send_word(eid_pkg::MODE_FREE, '0);
		send_word(eid_pkg::MODE_FREE, eid_pkg::ID_W'(3));
		send_word(eid_pkg::MODE_FREE, '1);
		send_word(eid_pkg::MODE_FREE, eid_pkg::ID_W'(5));
		send_word(eid_pkg::MODE_FREE, eid_pkg::ID_W'(5));
		send_word(eid_pkg::MODE_FREE, eid_pkg::ID_W'(6));
		repeat (4) send_word(eid_pkg::MODE_ALLOC, '0);
		send_word(eid_pkg::MODE_FILL, '1);
		send_word(eid_pkg::MODE_ALLOC, '0);
		send_word(MODE_SPARE_LO, '1);
		send_word(MODE_SPARE_MID, eid_pkg::ID_W'(512));
		send_word(MODE_SPARE_HI, '0);
		send_word(eid_pkg::MODE_CREATE, '0);
		wait_drained();
	endtask

	// long random run, the first part with no stalls on either side
	task automatic test_random_mix();
		no_gaps <= 1'b1;
		repeat (150) send_mixed_word();
		no_gaps <= 1'b0;
		repeat (600) send_mixed_word();
		wait_drained();
	endtask

	// response side held off while requests keep coming, then a full drain
	task automatic test_backpressure();
		hold_ask <= hold_ask + 1;
		repeat (24) send_mixed_word();
		wait_drained();
	endtask

	// counter exhaustion, full free list, overflowing fill
	task automatic test_pool_limits();
		int live_total;
		while (freed_depth > 0)
			send_word(eid_pkg::MODE_ALLOC, eid_pkg::ID_W'($urandom));
		send_word(eid_pkg::MODE_CREATE, eid_pkg::ID_W'(eid_pkg::ENTRY_COUNT - 1));
		repeat (3) send_word(eid_pkg::MODE_ALLOC, eid_pkg::ID_W'($urandom));
		send_word(eid_pkg::MODE_CREATE, eid_pkg::ID_W'(eid_pkg::ENTRY_COUNT - 1));
		live_total = 0;
		foreach (id_live[k])
			live_total += id_live[k];
		// more entries on the list than live IDs, so the fill cannot push all holes
		repeat (live_total + 3) send_word(eid_pkg::MODE_FREE, pick_live_id());
		send_word(eid_pkg::MODE_FILL, eid_pkg::ID_W'($urandom));
		send_word(eid_pkg::MODE_FREE, pick_live_id());
		repeat (10) send_word(eid_pkg::MODE_QUERY, eid_pkg::ID_W'($urandom));
		repeat (20) send_mixed_word();
		wait_drained();
	endtask

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.mode      = eid_pkg::MODE_ALLOC;
		req_ch.entity_id = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix();
		test_backpressure();
		test_pool_limits();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d alloc, %0d create, %0d free, %0d query, %0d fill, %0d spare-mode words",
			mode_count[eid_pkg::MODE_ALLOC], mode_count[eid_pkg::MODE_CREATE],
			mode_count[eid_pkg::MODE_FREE], mode_count[eid_pkg::MODE_QUERY],
			mode_count[eid_pkg::MODE_FILL],
			mode_count[MODE_SPARE_LO] + mode_count[MODE_SPARE_MID] + mode_count[MODE_SPARE_HI]);
		$display("Got ok %0d, full %0d, exists %0d, missing %0d, root %0d, overflow %0d; %0d errors",
			status_count[eid_pkg::ST_OK], status_count[eid_pkg::ST_FULL],
			status_count[eid_pkg::ST_EXISTS], status_count[eid_pkg::ST_MISSING],
			status_count[eid_pkg::ST_ROOT], status_count[eid_pkg::ST_OVERFLOW],
			fail_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
